// File: sv/cll_pkg.sv
`default_nettype none

package cll_pkg;

	localparam int ACTION_W = 3;
	localparam int VALUE_W = 16;
	localparam int INDEX_W = 8;

	localparam logic [ACTION_W-1:0] ACT_FIND = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_FIND_PREV = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_NEXT_IS_NULL = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_NEW_LIST = 3'd5;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [VALUE_W-1:0]  value;
		logic [INDEX_W-1:0]  list_head;
		logic [INDEX_W-1:0]  position;
	} req_word_t;

	typedef struct packed {
		logic [INDEX_W-1:0] result_position;
		logic               flag;
		logic               status;
	} rsp_word_t;

endpackage

`default_nettype wire

// File: sv/cll_store.sv
`default_nettype none

module cll_store #(
	parameter int NODE_COUNT = 256,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          next_we,
	input  wire logic [$clog2(NODE_COUNT)-1:0] next_wa,
	input  wire logic [$clog2(NODE_COUNT)-1:0] next_wd,
	input  wire logic                          elem_we,
	input  wire logic [$clog2(NODE_COUNT)-1:0] elem_wa,
	input  wire logic [ELEMENT_BITS-1:0]       elem_wd,
	input  wire logic [$clog2(NODE_COUNT)-1:0] rd_addr,
	output logic      [$clog2(NODE_COUNT)-1:0] next_rd,
	output logic      [ELEMENT_BITS-1:0]       elem_rd
);

	localparam int IW = $clog2(NODE_COUNT);

	logic [IW-1:0]           next_mem [NODE_COUNT];
	logic [ELEMENT_BITS-1:0] elem_mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd <= next_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_mem[elem_wa] <= elem_wd;
		end
		elem_rd <= elem_mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: sv/cursor_linked_list_engine.sv
// one request at a time; the next word is taken the cycle after a result is produced
// find, find_previous, delete: walk the list from its head, one store read per node walked
// delete relinks in S_RDX, S_LINK, S_WFIN; insert and new_list take a free node in S_TAKE
// index folding repeats S_NORM, subtracting NODE_COUNT each time, when NODE_COUNT is below 256
// after reset S_CLEAR builds the free chain over all NODE_COUNT nodes; requests stall meanwhile
`default_nettype none

module cursor_linked_list_engine #(
	parameter int NODE_COUNT = 256,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire cll_pkg::req_word_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output cll_pkg::rsp_word_t     rsp
);

	localparam int IW = $clog2(NODE_COUNT);
	localparam int SW = $clog2(NODE_COUNT + 1);
	localparam logic [IW-1:0] LAST_NODE = IW'(NODE_COUNT - 1);
	localparam logic [SW-1:0] STEP_LIMIT = SW'(NODE_COUNT);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_NORM = 4'd2;
	localparam logic [3:0] S_HEAD = 4'd3;
	localparam logic [3:0] S_WALK = 4'd4;
	localparam logic [3:0] S_TAKE = 4'd5;
	localparam logic [3:0] S_RDX = 4'd6;
	localparam logic [3:0] S_LINK = 4'd7;
	localparam logic [3:0] S_WFIN = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]                      state_q;
	logic [IW-1:0]                   clr_q;
	logic [cll_pkg::ACTION_W-1:0]    act_q;
	logic [ELEMENT_BITS-1:0]         x_q;
	logic [cll_pkg::INDEX_W-1:0]     h_q;
	logic [cll_pkg::INDEX_W-1:0]     pos_q;
	logic [IW-1:0]                   cur_q;
	logic [IW-1:0]                   prv_q;
	logic [IW-1:0]                   t_q;
	logic [IW-1:0]                   rx_q;
	logic [IW-1:0]                   fa_q;
	logic [IW-1:0]                   fd_q;
	logic [SW-1:0]                   steps_q;
	logic [cll_pkg::INDEX_W-1:0]     res_q;
	logic                            flag_q;
	logic                            status_q;
	logic                            rsp_valid_q;
	cll_pkg::rsp_word_t              rsp_q;

	logic [IW-1:0]           rd_addr;
	logic                    next_we;
	logic [IW-1:0]           next_wa;
	logic [IW-1:0]           next_wd;
	logic                    elem_we;
	logic [IW-1:0]           next_rd;
	logic [ELEMENT_BITS-1:0] elem_rd;

	logic          h_fold;
	logic          pos_fold;
	logic [IW-1:0] h_idx;
	logic [IW-1:0] pos_idx;
	logic          match;
	logic          at_bound;
	logic          walk_act;
	logic          take_act;
	logic          out_free;

	assign h_fold = 32'(h_q) >= NODE_COUNT;
	assign pos_fold = 32'(pos_q) >= NODE_COUNT;
	assign h_idx = IW'(h_q);
	assign pos_idx = IW'(pos_q);
	assign match = elem_rd == x_q;
	assign at_bound = steps_q == STEP_LIMIT;
	assign walk_act = (act_q == cll_pkg::ACT_FIND) || (act_q == cll_pkg::ACT_FIND_PREV)
		|| (act_q == cll_pkg::ACT_DELETE);
	assign take_act = (act_q == cll_pkg::ACT_INSERT) || (act_q == cll_pkg::ACT_NEW_LIST);
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	cll_store #(
		.NODE_COUNT(NODE_COUNT),
		.ELEMENT_BITS(ELEMENT_BITS)
	) u_store (
		.clk(clk),
		.next_we(next_we),
		.next_wa(next_wa),
		.next_wd(next_wd),
		.elem_we(elem_we),
		.elem_wa(t_q),
		.elem_wd(x_q),
		.rd_addr(rd_addr),
		.next_rd(next_rd),
		.elem_rd(elem_rd)
	);

	always_comb begin
		rd_addr = '0;
		next_we = 1'b0;
		next_wa = '0;
		next_wd = '0;
		elem_we = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				next_we = 1'b1;
				next_wa = clr_q;
				next_wd = (clr_q == LAST_NODE) ? '0 : clr_q + IW'(1);
			end
			S_NORM: begin
				if (walk_act) begin
					rd_addr = h_idx;
				end else if (act_q == cll_pkg::ACT_NEXT_IS_NULL) begin
					rd_addr = pos_idx;
				end
			end
			S_HEAD: begin
				rd_addr = next_rd;
			end
			S_WALK: begin
				rd_addr = next_rd;
				if (match && act_q == cll_pkg::ACT_DELETE) begin
					next_we = 1'b1;
					next_wa = prv_q;
					next_wd = next_rd;
				end
			end
			S_TAKE: begin
				next_we = 1'b1;
				next_wd = next_rd;
				elem_we = act_q == cll_pkg::ACT_INSERT;
			end
			S_RDX: begin
				rd_addr = rx_q;
			end
			S_LINK: begin
				next_we = 1'b1;
				next_wa = t_q;
				next_wd = next_rd;
			end
			S_WFIN: begin
				next_we = 1'b1;
				next_wa = fa_q;
				next_wd = fd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			steps_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST_NODE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						act_q <= req.action;
						x_q <= ELEMENT_BITS'(req.value);
						h_q <= req.list_head;
						pos_q <= req.position;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (h_fold || pos_fold) begin
						if (h_fold) begin
							h_q <= h_q - cll_pkg::INDEX_W'(NODE_COUNT);
						end
						if (pos_fold) begin
							pos_q <= pos_q - cll_pkg::INDEX_W'(NODE_COUNT);
						end
					end else begin
						res_q <= '0;
						flag_q <= 1'b0;
						status_q <= 1'b0;
						steps_q <= '0;
						prv_q <= h_idx;
						if (walk_act || take_act || act_q == cll_pkg::ACT_NEXT_IS_NULL) begin
							state_q <= S_HEAD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_HEAD: begin
					if (act_q == cll_pkg::ACT_NEXT_IS_NULL) begin
						flag_q <= next_rd == '0;
						state_q <= S_DONE;
					end else if (take_act) begin
						if (next_rd == '0) begin
							status_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							t_q <= next_rd;
							state_q <= S_TAKE;
						end
					end else if (next_rd == '0) begin
						if (act_q == cll_pkg::ACT_FIND_PREV) begin
							res_q <= cll_pkg::INDEX_W'(prv_q);
						end
						state_q <= S_DONE;
					end else begin
						cur_q <= next_rd;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (match) begin
						state_q <= S_DONE;
						if (act_q == cll_pkg::ACT_FIND_PREV) begin
							res_q <= cll_pkg::INDEX_W'(prv_q);
						end else begin
							res_q <= cll_pkg::INDEX_W'(cur_q);
						end
						if (act_q == cll_pkg::ACT_DELETE) begin
							flag_q <= 1'b1;
							t_q <= cur_q;
							rx_q <= '0;
							fa_q <= '0;
							fd_q <= cur_q;
							state_q <= S_RDX;
						end
					end else if (at_bound) begin
						state_q <= S_DONE;
					end else begin
						prv_q <= cur_q;
						cur_q <= next_rd;
						steps_q <= steps_q + SW'(1);
						if (next_rd == '0) begin
							if (act_q == cll_pkg::ACT_FIND_PREV) begin
								res_q <= cll_pkg::INDEX_W'(cur_q);
							end
							state_q <= S_DONE;
						end
					end
				end
				S_TAKE: begin
					res_q <= cll_pkg::INDEX_W'(t_q);
					if (act_q == cll_pkg::ACT_INSERT) begin
						rx_q <= pos_idx;
						fa_q <= pos_idx;
						fd_q <= t_q;
						state_q <= S_RDX;
					end else begin
						fa_q <= t_q;
						fd_q <= '0;
						state_q <= S_WFIN;
					end
				end
				S_RDX: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					state_q <= S_WFIN;
				end
				S_WFIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_q.result_position <= res_q;
			rsp_q.flag <= flag_q;
			rsp_q.status <= status_q;
		end
	end

	a_walk_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> cur_q != '0)
		else $error("walk on null node");

	a_accept_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> state_q == S_NORM)
		else $error("accepted word not taken into folding");

	a_link_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK || state_q == S_TAKE) |-> t_q != '0)
		else $error("relink of null node");

	a_flag_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.flag && rsp.status))
		else $error("flag and status both set");

endmodule

`default_nettype wire

// File: verif/tb_cursor_linked_list_engine.sv
`default_nettype none

module tb_cursor_linked_list_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 256;
	localparam int RANDOM_ITEMS = 1525;
	localparam int LONG_HOLD = 400;
	localparam int WATCHDOG = 4000;
	localparam int TAIL_CYCLES = 300;

	localparam logic [cll_pkg::ACTION_W-1:0] ACT_UNUSED_LO = 3'd6;
	localparam logic [cll_pkg::ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;
	localparam logic ST_OK = 1'b0;
	localparam logic ST_NO_FREE = 1'b1;

	typedef enum logic [1:0] {STAGE_MIX, STAGE_FILL, STAGE_DRAIN} stage_t;

	typedef struct {
		cll_pkg::req_word_t w;
		bit                 typed;
		cll_pkg::rsp_word_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	cll_pkg::req_word_t req;
	logic rsp_valid;
	logic rsp_stall;
	cll_pkg::rsp_word_t rsp;

	logic [cll_pkg::VALUE_W-1:0] node_val [NODES];
	logic [cll_pkg::INDEX_W-1:0] node_link [NODES];
	bit                          val_set [NODES];
	bit                          blank_seen;

	cll_pkg::rsp_word_t          due_rsp [$];
	logic [cll_pkg::INDEX_W-1:0] heads [$];
	logic [cll_pkg::INDEX_W-1:0] chain_q [$];
	script_row_t                 script [$];
	int                          errors = 0;
	int                          full_hits = 0;

	cursor_linked_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// first node after h holding x, 0 when absent or the walk runs out
	function automatic logic [cll_pkg::INDEX_W-1:0] seek_match(
			input logic [cll_pkg::VALUE_W-1:0] x, input logic [cll_pkg::INDEX_W-1:0] h);
		logic [cll_pkg::INDEX_W-1:0] p;
		int steps;
		p = node_link[h];
		steps = 0;
		while (p != 0) begin
			if (!val_set[p]) blank_seen = 1'b1;
			if (node_val[p] == x) break;
			if (steps >= NODES) begin
				p = '0;
				break;
			end
			p = node_link[p];
			steps++;
		end
		return p;
	endfunction

	// node before the first match, or the last node; 0 return when the walk runs out
	function automatic bit seek_pred(input logic [cll_pkg::VALUE_W-1:0] x,
			input logic [cll_pkg::INDEX_W-1:0] h, output logic [cll_pkg::INDEX_W-1:0] pred);
		logic [cll_pkg::INDEX_W-1:0] p;
		int steps;
		pred = '0;
		p = h;
		steps = 0;
		while (node_link[p] != 0) begin
			if (!val_set[node_link[p]]) blank_seen = 1'b1;
			if (node_val[node_link[p]] == x) break;
			if (steps >= NODES) return 1'b0;
			p = node_link[p];
			steps++;
		end
		pred = p;
		return 1'b1;
	endfunction

	function automatic bit reads_blank(input cll_pkg::req_word_t w);
		logic [cll_pkg::INDEX_W-1:0] p;
		blank_seen = 1'b0;
		if (w.action == cll_pkg::ACT_FIND)
			p = seek_match(w.value, w.list_head);
		else if (w.action == cll_pkg::ACT_FIND_PREV || w.action == cll_pkg::ACT_DELETE)
			void'(seek_pred(w.value, w.list_head, p));
		return blank_seen;
	endfunction

	// carries out one request on the node store and returns its result word
	function automatic cll_pkg::rsp_word_t apply_action(input cll_pkg::req_word_t w);
		cll_pkg::rsp_word_t o;
		logic [cll_pkg::INDEX_W-1:0] p;
		logic [cll_pkg::INDEX_W-1:0] t;
		o = '0;
		o.status = ST_OK;
		case (w.action)
			cll_pkg::ACT_FIND: begin
				o.result_position = seek_match(w.value, w.list_head);
			end
			cll_pkg::ACT_FIND_PREV: begin
				if (seek_pred(w.value, w.list_head, p)) o.result_position = p;
			end
			cll_pkg::ACT_DELETE: begin
				if (seek_pred(w.value, w.list_head, p)) begin
					if (node_link[p] != 0) begin
						t = node_link[p];
						node_link[p] = node_link[t];
						node_link[t] = node_link[0];
						node_link[0] = t;
						o.result_position = t;
						o.flag = 1'b1;
					end
				end
			end
			cll_pkg::ACT_INSERT: begin
				if (node_link[0] != 0) begin
					t = node_link[0];
					node_link[0] = node_link[t];
					node_val[t] = w.value;
					val_set[t] = 1'b1;
					node_link[t] = node_link[w.position];
					node_link[w.position] = t;
					o.result_position = t;
				end else begin
					o.status = ST_NO_FREE;
				end
			end
			cll_pkg::ACT_NEXT_IS_NULL: begin
				o.flag = (node_link[w.position] == 0);
			end
			cll_pkg::ACT_NEW_LIST: begin
				if (node_link[0] != 0) begin
					t = node_link[0];
					node_link[0] = node_link[t];
					node_link[t] = '0;
					o.result_position = t;
				end else begin
					o.status = ST_NO_FREE;
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic void gather(input logic [cll_pkg::INDEX_W-1:0] h);
		logic [cll_pkg::INDEX_W-1:0] p;
		int steps;
		chain_q.delete();
		p = node_link[h];
		steps = 0;
		while (p != 0 && steps < NODES) begin
			chain_q.push_back(p);
			p = node_link[p];
			steps++;
		end
	endfunction

	function automatic cll_pkg::req_word_t pick_word(input stage_t stage);
		cll_pkg::req_word_t w;
		int r;
		logic [cll_pkg::INDEX_W-1:0] h;
		w.action = cll_pkg::ACTION_W'($urandom_range(7));
		w.value = cll_pkg::VALUE_W'($urandom);
		w.list_head = cll_pkg::INDEX_W'($urandom);
		w.position = cll_pkg::INDEX_W'($urandom);
		// noise
		if ($urandom_range(99) < 6) return w;
		if (heads.size() == 0) begin
			w.action = cll_pkg::ACT_NEW_LIST;
			return w;
		end
		h = heads[$urandom_range(heads.size() - 1)];
		gather(h);
		w.list_head = h;
		if (chain_q.size() != 0 && $urandom_range(3) != 0)
			w.value = node_val[chain_q[$urandom_range(chain_q.size() - 1)]];
		if (chain_q.size() == 0 || $urandom_range(4) == 0)
			w.position = h;
		else
			w.position = chain_q[$urandom_range(chain_q.size() - 1)];
		r = $urandom_range(99);
		case (stage)
			STAGE_FILL: begin
				w.action = (r < 85) ? cll_pkg::ACT_INSERT : (r < 92) ? cll_pkg::ACT_FIND :
					cll_pkg::ACT_NEXT_IS_NULL;
			end
			STAGE_DRAIN: begin
				w.action = (r < 70) ? cll_pkg::ACT_DELETE : (r < 85) ? cll_pkg::ACT_FIND :
					(r < 95) ? cll_pkg::ACT_FIND_PREV : cll_pkg::ACT_INSERT;
			end
			default: begin
				w.action = (r < 22) ? cll_pkg::ACT_FIND : (r < 38) ? cll_pkg::ACT_FIND_PREV :
					(r < 55) ? cll_pkg::ACT_DELETE : (r < 80) ? cll_pkg::ACT_INSERT :
					(r < 93) ? cll_pkg::ACT_NEXT_IS_NULL : cll_pkg::ACT_NEW_LIST;
			end
		endcase
		if (w.action == cll_pkg::ACT_NEW_LIST && heads.size() >= 10)
			w.action = cll_pkg::ACT_INSERT;
		return w;
	endfunction

	function automatic void row(input logic [cll_pkg::ACTION_W-1:0] act,
			input logic [cll_pkg::VALUE_W-1:0] val, input logic [cll_pkg::INDEX_W-1:0] hd,
			input logic [cll_pkg::INDEX_W-1:0] pos, input bit typed,
			input logic [cll_pkg::INDEX_W-1:0] res, input logic flg, input logic st);
		script_row_t s;
		s.w.action = act;
		s.w.value = val;
		s.w.list_head = hd;
		s.w.position = pos;
		s.typed = typed;
		s.want.result_position = res;
		s.want.flag = flg;
		s.want.status = st;
		script.push_back(s);
	endfunction

	task automatic push_word(input cll_pkg::req_word_t w, input int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic offer(input cll_pkg::req_word_t w, input bit typed,
			input cll_pkg::rsp_word_t want, input int gap);
		cll_pkg::rsp_word_t calc;
		calc = apply_action(w);
		if (w.action == cll_pkg::ACT_NEW_LIST && calc.status == ST_OK) begin
			heads.push_back(calc.result_position);
			if (heads.size() > 16) void'(heads.pop_front());
		end
		if (calc.status == ST_NO_FREE) full_hits++;
		due_rsp.push_back(typed ? want : calc);
		push_word(w, gap);
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (due_rsp.size() != 0);
	endtask

	task automatic check_rsp(input cll_pkg::rsp_word_t got);
		cll_pkg::rsp_word_t want;
		if (due_rsp.size() == 0) begin
			$error("unexpected word: result_position %0d flag %0d status %0d",
				got.result_position, got.flag, got.status);
			errors++;
			return;
		end
		want = due_rsp.pop_front();
		if (got.result_position !== want.result_position) begin
			$error("result_position: expected %0d, got %0d", want.result_position,
				got.result_position);
			errors++;
		end
		if (got.flag !== want.flag) begin
			$error("flag: expected %0d, got %0d", want.flag, got.flag);
			errors++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
	endtask

	initial begin : stimulus
		cll_pkg::req_word_t w;
		cll_pkg::rsp_word_t none;
		stage_t stage;
		int placed;
		int phase;
		int span;
		int gap_cap;
		int tries;
		int fill_mark;
		bit phase_over;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		none = '0;
		for (int i = 0; i < NODES; i++) begin
			node_val[i] = '0;
			val_set[i] = 1'b0;
			node_link[i] = cll_pkg::INDEX_W'((i + 1) % NODES);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		row(cll_pkg::ACT_NEXT_IS_NULL, 16'h0000, 8'd0, 8'd255, 1'b1, 8'd0, 1'b1, ST_OK);
		row(cll_pkg::ACT_NEXT_IS_NULL, 16'hFFFF, 8'd255, 8'd0, 1'b1, 8'd0, 1'b0, ST_OK);
		row(ACT_UNUSED_LO, 16'hFFFF, 8'd255, 8'd255, 1'b1, 8'd0, 1'b0, ST_OK);
		row(ACT_UNUSED_HI, 16'h0000, 8'd0, 8'd0, 1'b1, 8'd0, 1'b0, ST_OK);
		// insert after the free head leaves the taken node at the head
		row(cll_pkg::ACT_INSERT, 16'hFFFF, 8'd0, 8'd0, 1'b1, 8'd1, 1'b0, ST_OK);
		row(cll_pkg::ACT_NEW_LIST, 16'h0000, 8'd0, 8'd0, 1'b1, 8'd1, 1'b0, ST_OK);
		row(cll_pkg::ACT_INSERT, 16'h0000, 8'd1, 8'd1, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_INSERT, 16'h1234, 8'd1, 8'd2, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_INSERT, 16'hFFFF, 8'd1, 8'd1, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_FIND, 16'h1234, 8'd1, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_FIND, 16'hFFFF, 8'd1, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_FIND_PREV, 16'h1234, 8'd1, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_FIND, 16'hBEEF, 8'd1, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_FIND_PREV, 16'hBEEF, 8'd1, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_NEXT_IS_NULL, 16'h0000, 8'd1, 8'd3, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_NEXT_IS_NULL, 16'h0000, 8'd1, 8'd1, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_DELETE, 16'h0000, 8'd1, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_DELETE, 16'h0000, 8'd1, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		// free chain searched as a list
		row(cll_pkg::ACT_FIND, 16'h0000, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		// position equal to the free head gives a self loop
		row(cll_pkg::ACT_INSERT, 16'hA5A5, 8'd0, 8'd2, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_FIND, 16'h5A5A, 8'd2, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_FIND_PREV, 16'h5A5A, 8'd2, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_DELETE, 16'h5A5A, 8'd2, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_FIND_PREV, 16'hA5A5, 8'd2, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
		row(cll_pkg::ACT_DELETE, 16'hA5A5, 8'd2, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);

		foreach (script[i])
			offer(script[i].w, script[i].typed, script[i].want, $urandom_range(16));
		hold_until_drained();

		placed = 0;
		phase = 0;
		while (placed < RANDOM_ITEMS) begin
			stage = stage_t'(phase % 3);
			gap_cap = (phase % 4 == 0) ? 0 : (phase % 4 == 2) ? 4 : 16;
			span = 0;
			fill_mark = full_hits;
			phase_over = 1'b0;
			while (placed < RANDOM_ITEMS && !phase_over) begin
				tries = 0;
				do begin
					w = pick_word(stage);
					tries++;
				end while (reads_blank(w) && tries < 30);
				// never walk over nodes whose element was not written
				if (reads_blank(w)) w.action = cll_pkg::ACT_NEXT_IS_NULL;
				offer(w, 1'b0, none, $urandom_range(gap_cap));
				placed++;
				span++;
				case (stage)
					STAGE_FILL: phase_over = (full_hits - fill_mark >= 6) || span >= 320;
					STAGE_DRAIN: phase_over = span >= 220;
					default: phase_over = span >= 80;
				endcase
			end
			if (phase % 2 == 1) hold_until_drained();
			phase++;
		end
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("cursor_linked_list_engine regression: pass");
		else
			$display("cursor_linked_list_engine regression: fail");
		$finish;
	end

	initial begin : sink
		int hold;
		int freeze;
		int cap;
		int seen;
		hold = 0;
		freeze = 0;
		cap = 16;
		seen = 0;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				check_rsp(rsp);
				seen++;
				if (seen % 64 == 0) cap = (seen / 64 % 3 == 0) ? 16 : (seen / 64 % 3 == 1) ? 0 : 4;
				hold = $urandom_range(cap);
				// long hold-off so the block backs up onto its input
				if (seen == 300 || seen == 1000) freeze = LONG_HOLD;
			end else if (rsp_valid && rsp_stall && hold > 0) begin
				hold--;
			end
			if (freeze > 0) freeze--;
			rsp_stall <= (freeze > 0) || (hold > 0);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("cursor_linked_list_engine regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
